FILE: sv/ftt_pkg.sv
`timescale 1ns / 1ps
package ftt_pkg;
   localparam int unsigned KeyWidth = 104;
   localparam int unsigned TableDepth = 1024;
   localparam logic [31:0] FnvBasis = 32'd2166136261;
   localparam logic [31:0] FnvPrime = 32'd16777619;
   localparam logic [7:0] ProtoTcp = 8'd6;
   localparam logic [7:0] ProtoUdp = 8'd17;

   typedef enum logic [1:0] {
      CMD_RECORD = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_READ   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IGNORED = 3'd0,
      ST_NEW     = 3'd1,
      ST_HIT     = 3'd2,
      ST_EVICTED = 3'd3,
      ST_CLEARED = 3'd4,
      ST_READ    = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        is_ipv4;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] l4_src;
      logic [15:0] l4_dst;
      logic [7:0]  proto;
      logic [15:0] pkt_len;
      logic [63:0] now_ns;
      logic [9:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  slot;
      logic        slot_active;
      logic [63:0] flow_pkts;
      logic [63:0] flow_bytes;
      logic [63:0] window_pkts;
      logic [63:0] window_bytes;
      logic [63:0] seen_time;
      logic [10:0] live_flows;
      logic [63:0] all_pkts;
      logic [63:0] all_bytes;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;   // latch request, build key
      logic [2:0] hash_step; // hash round select: word 0 to 3 of the key
      logic       hash_en;
      logic       probe_start;
      logic       mem_read;  // read slot at the table pointer
      logic       eval;      // examine read data
      logic       clr_read;  // sweep read
      logic       clr_write; // sweep write-back
      logic       commit;    // write the chosen slot and build the result
      logic [2:0] commit_status;
      logic       read_load; // load the pointer from the read index
      logic       read_out;  // build the read result
      logic       plain_out; // build a result without slot data
      logic [2:0] plain_status;
      logic       sweep_start;
      logic       init_write;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic found_empty;
      logic found_match;
      logic probe_last;
      logic sweep_last;
   } sts_type;
endpackage

FILE: sv/ftt_if.sv
`timescale 1ns / 1ps
interface ftt_req_if;
   logic valid;
   logic ready;
   ftt_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ftt_rsp_if;
   logic valid;
   logic ready;
   ftt_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: sv/flow_table_tracker.sv
`timescale 1ns / 1ps
// Record: the key is hashed, then n slots are probed (1 to 16), then the chosen slot is
// written and the result registered.
// Read: the slot is read, then the result registered; an ignored item needs no table access.
// Period clear: each slot read and written back; one item in flight; one read, one write port.
// Reset is synchronous, active high; after it a clearing pass writes every slot, one per
// cycle, and no item is accepted until it ends.
module flow_table_tracker #(
   parameter int unsigned PROBE_LIMIT = 16
) (
   input logic   clock,
   input logic   reset,
   ftt_req_if.sink   req,
   ftt_rsp_if.source rsp
);
   ftt_pkg::ctl_type ctl;
   ftt_pkg::sts_type sts;

   ftt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_data  (req.data),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   ftt_datapath #(
      .PROBE_LIMIT (PROBE_LIMIT)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req.data),
      .ctl      (ctl),
      .sts      (sts),
      .rsp_data (rsp.data)
   );
endmodule

FILE: sv/ftt_datapath.sv
`timescale 1ns / 1ps
module ftt_datapath #(
   parameter int unsigned PROBE_LIMIT = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  ftt_pkg::req_type  req_data,
   input  ftt_pkg::ctl_type  ctl,
   output ftt_pkg::sts_type  sts,
   output ftt_pkg::rsp_type  rsp_data
);
   localparam int unsigned AW = $clog2(ftt_pkg::TableDepth);
   localparam int unsigned PW = $clog2(PROBE_LIMIT + 1);
   localparam int unsigned KW = ftt_pkg::KeyWidth;
   // Entry: valid, key, total pkts, total bytes, period pkts, period bytes, seen.
   localparam int unsigned EW = 1 + KW + 5 * 64;

   typedef struct packed {
      logic          valid;
      logic [KW-1:0] key;
      logic [63:0]   tpk;
      logic [63:0]   tby;
      logic [63:0]   ppk;
      logic [63:0]   pby;
      logic [63:0]   seen;
   } entry_type;

   logic [EW-1:0] mem [ftt_pkg::TableDepth];

   ftt_pkg::req_type req_ff;
   logic [KW-1:0] key_ff;
   logic [31:0]   hash_ff, hash_in, mix;
   logic [AW-1:0] ptr_ff, tgt_ff;
   logic [PW-1:0] cnt_ff;
   logic [63:0]   old_t_ff;
   logic          have_old_ff;
   entry_type     rd_ff, rd_q;
   logic [AW-1:0] rd_addr_ff;
   logic          found_empty_ff, found_match_ff;
   logic [10:0]   active_ff;
   logic [63:0]   sum_pkts_ff, sum_bytes_ff;
   ftt_pkg::rsp_type rsp_ff;
   entry_type     wr_e;
   logic [AW-1:0] wr_a;
   logic          wr_en;

   assign rd_q = rd_ff;

   // One FNV-1a-style round on a 32-bit key word per cycle, multiplier registered.
   always_comb begin
      logic [31:0] w;
      unique case (ctl.hash_step)
         3'd0:    w = key_ff[103:72];
         3'd1:    w = key_ff[71:40];
         3'd2:    w = key_ff[39:8];
         default: w = {24'd0, key_ff[7:0]};
      endcase
      mix = hash_ff ^ w;
      hash_in = mix * ftt_pkg::FnvPrime;
   end

   // Memory write selection.
   always_comb begin
      wr_en = 1'b0;
      wr_a = tgt_ff;
      wr_e = rd_q;
      if (ctl.init_write) begin
         wr_en = 1'b1;
         wr_a = ptr_ff;
         wr_e = '0;
      end else if (ctl.clr_write) begin
         wr_en = 1'b1;
         wr_a = rd_addr_ff;
         wr_e = rd_q;
         if (rd_q.valid) begin
            wr_e.ppk = '0;
            wr_e.pby = '0;
         end
      end else if (ctl.commit) begin
         wr_en = 1'b1;
         wr_a = tgt_ff;
         if (ctl.commit_status == ftt_pkg::ST_HIT) begin
            wr_e = rd_q;
            wr_e.tpk = rd_q.tpk + 64'd1;
            wr_e.tby = rd_q.tby + {48'd0, req_ff.pkt_len};
            wr_e.ppk = rd_q.ppk + 64'd1;
            wr_e.pby = rd_q.pby + {48'd0, req_ff.pkt_len};
            wr_e.seen = req_ff.now_ns;
         end else begin
            wr_e.valid = 1'b1;
            wr_e.key = key_ff;
            wr_e.tpk = 64'd1;
            wr_e.tby = {48'd0, req_ff.pkt_len};
            wr_e.ppk = 64'd1;
            wr_e.pby = {48'd0, req_ff.pkt_len};
            wr_e.seen = req_ff.now_ns;
         end
      end
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_a] <= wr_e;
      end
      if (ctl.mem_read || ctl.clr_read) begin
         rd_ff <= mem[ptr_ff];
         rd_addr_ff <= ptr_ff;
      end
   end

   // Table pointer for probing, reads, the clear sweep and the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (ctl.probe_start) begin
         ptr_ff <= hash_ff[AW-1:0];
      end else if (ctl.sweep_start) begin
         ptr_ff <= '0;
      end else if (ctl.read_load) begin
         ptr_ff <= req_ff.read_index[AW-1:0];
      end else if (ctl.mem_read || ctl.clr_read || ctl.init_write) begin
         ptr_ff <= ptr_ff + AW'(1);
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         req_ff <= req_data;
         hash_ff <= ftt_pkg::FnvBasis;
         if (req_data.proto == ftt_pkg::ProtoTcp || req_data.proto == ftt_pkg::ProtoUdp) begin
            key_ff <= {req_data.src_ip, req_data.dst_ip, req_data.l4_src,
                       req_data.l4_dst, req_data.proto};
         end else begin
            key_ff <= {req_data.src_ip, req_data.dst_ip, 32'd0, req_data.proto};
         end
      end
      if (ctl.hash_en) begin
         hash_ff <= hash_in;
      end
      if (ctl.probe_start) begin
         cnt_ff <= '0;
         have_old_ff <= 1'b0;
         found_empty_ff <= 1'b0;
         found_match_ff <= 1'b0;
         tgt_ff <= hash_ff[AW-1:0];
      end
      if (ctl.mem_read) begin
         cnt_ff <= cnt_ff + PW'(1);
      end
      // Examine a probed slot: empty, match, or eviction candidate.
      if (ctl.eval) begin
         if (!rd_q.valid) begin
            found_empty_ff <= 1'b1;
            tgt_ff <= rd_addr_ff;
         end else if (rd_q.key == key_ff) begin
            found_match_ff <= 1'b1;
            tgt_ff <= rd_addr_ff;
         end else if (!have_old_ff || rd_q.seen < old_t_ff) begin
            have_old_ff <= 1'b1;
            old_t_ff <= rd_q.seen;
            tgt_ff <= rd_addr_ff;
         end
      end
   end

   // Global counters.
   always_ff @(posedge clock) begin
      if (ctl.init_write && ptr_ff == '0) begin
         active_ff <= '0;
         sum_pkts_ff <= '0;
         sum_bytes_ff <= '0;
      end
      if (ctl.commit) begin
         sum_pkts_ff <= sum_pkts_ff + 64'd1;
         sum_bytes_ff <= sum_bytes_ff + {48'd0, req_ff.pkt_len};
         if (ctl.commit_status == ftt_pkg::ST_NEW) begin
            active_ff <= active_ff + 11'd1;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_ff.status <= ctl.commit_status;
         rsp_ff.slot <= 10'(tgt_ff);
         rsp_ff.slot_active <= 1'b1;
         rsp_ff.flow_pkts <= wr_e.tpk;
         rsp_ff.flow_bytes <= wr_e.tby;
         rsp_ff.window_pkts <= wr_e.ppk;
         rsp_ff.window_bytes <= wr_e.pby;
         rsp_ff.seen_time <= wr_e.seen;
         rsp_ff.live_flows <= (ctl.commit_status == ftt_pkg::ST_NEW) ?
                              active_ff + 11'd1 : active_ff;
         rsp_ff.all_pkts <= sum_pkts_ff + 64'd1;
         rsp_ff.all_bytes <= sum_bytes_ff + {48'd0, req_ff.pkt_len};
      end else if (ctl.read_out) begin
         rsp_ff.status <= ftt_pkg::ST_READ;
         rsp_ff.slot <= 10'(rd_addr_ff);
         rsp_ff.slot_active <= rd_q.valid;
         rsp_ff.flow_pkts <= rd_q.tpk;
         rsp_ff.flow_bytes <= rd_q.tby;
         rsp_ff.window_pkts <= rd_q.ppk;
         rsp_ff.window_bytes <= rd_q.pby;
         rsp_ff.seen_time <= rd_q.seen;
         rsp_ff.live_flows <= active_ff;
         rsp_ff.all_pkts <= sum_pkts_ff;
         rsp_ff.all_bytes <= sum_bytes_ff;
      end else if (ctl.plain_out) begin
         rsp_ff <= '0;
         rsp_ff.status <= ctl.plain_status;
         rsp_ff.live_flows <= active_ff;
         rsp_ff.all_pkts <= sum_pkts_ff;
         rsp_ff.all_bytes <= sum_bytes_ff;
      end
   end

   assign sts.found_empty = found_empty_ff;
   assign sts.found_match = found_match_ff;
   assign sts.probe_last = (cnt_ff == PW'(PROBE_LIMIT));
   assign sts.sweep_last = (ptr_ff == AW'(ftt_pkg::TableDepth - 1));
   assign rsp_data = rsp_ff;
endmodule

FILE: sv/ftt_ctrl.sv
`timescale 1ns / 1ps
module ftt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ftt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  ftt_pkg::sts_type sts,
   output ftt_pkg::ctl_type ctl
);
   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_HASH, S_PSTART, S_PREAD, S_PEVAL,
      S_COMMIT, S_RLOAD, S_RREAD, S_ROUT, S_CREAD, S_CWRITE, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] round_ff, round_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       first_ff, first_in;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      first_in = first_ff;
      ctl = '0;
      ctl.hash_step = {1'b0, round_ff};
      unique case (state_ff)
         S_INIT: begin
            ctl.init_write = 1'b1;
            if (sts.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               ctl.capture = 1'b1;
               round_in = '0;
               priority case (ftt_pkg::cmd_type'(req_data.cmd))
                  ftt_pkg::CMD_CLEAR: state_in = S_PSTART;
                  ftt_pkg::CMD_READ: state_in = S_RLOAD;
                  default: begin
                     if (req_data.cmd == ftt_pkg::CMD_RECORD && req_data.is_ipv4)
                        state_in = S_HASH;
                     else
                        state_in = S_OUT;
                  end
               endcase
            end
         end
         S_HASH: begin
            // The round count holds at the last round to mark a record.
            ctl.hash_en = 1'b1;
            if (round_ff == 2'd3) begin
               state_in = S_PSTART;
            end else begin
               round_in = round_ff + 2'd1;
            end
         end
         S_PSTART: begin
            // Shared start for probing and the clear sweep.
            first_in = 1'b0;
            if (round_ff == 2'd0) begin
               ctl.sweep_start = 1'b1;
               state_in = S_CREAD;
            end else begin
               ctl.probe_start = 1'b1;
               state_in = S_PREAD;
            end
         end
         S_PREAD: begin
            if (sts.found_empty || sts.found_match || sts.probe_last) begin
               state_in = S_COMMIT;
            end else begin
               ctl.mem_read = 1'b1;
               state_in = S_PEVAL;
            end
         end
         S_PEVAL: begin
            ctl.eval = 1'b1;
            state_in = S_PREAD;
         end
         S_COMMIT: begin
            ctl.commit = 1'b1;
            if (sts.found_empty) ctl.commit_status = ftt_pkg::ST_NEW;
            else if (sts.found_match) ctl.commit_status = ftt_pkg::ST_HIT;
            else ctl.commit_status = ftt_pkg::ST_EVICTED;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_RLOAD: begin
            ctl.read_load = 1'b1;
            state_in = S_RREAD;
         end
         S_RREAD: begin
            ctl.mem_read = 1'b1;
            state_in = S_ROUT;
         end
         S_ROUT: begin
            ctl.read_out = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_CREAD: begin
            ctl.clr_read = 1'b1;
            first_in = sts.sweep_last;
            state_in = S_CWRITE;
         end
         S_CWRITE: begin
            ctl.clr_write = 1'b1;
            if (first_ff) state_in = S_OUT;
            else state_in = S_CREAD;
         end
         S_OUT: begin
            ctl.plain_out = 1'b1;
            ctl.plain_status = (state_ff == S_OUT && first_ff) ?
                               ftt_pkg::ST_CLEARED : ftt_pkg::ST_IGNORED;
            rsp_valid_in = 1'b1;
            first_in = 1'b0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         round_ff <= '0;
         rsp_valid_ff <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff <= first_in;
      end
   end
endmodule
